// ===== src/rfd_pkg.sv =====
package rfd_pkg;

   localparam logic [7:0] HdrFirst   = 8'hFF;
   localparam logic [7:0] HdrSecond  = 8'h55;
   localparam int         PayLenSix  = 4;
   localparam int         PayLenNine = 7;
   localparam int         StoreDepth = 7;
   localparam int         QueueDepth = 2;
   localparam int         CsrAddrW   = 3;
   localparam int         CsrDataW   = 32;

   typedef enum logic {
      MODE_SIX  = 1'b0,
      MODE_NINE = 1'b1
   } frame_mode_type;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      frame_mode_type             mode;
      byte_type [StoreDepth-1:0]  pay;
   } frame_rec_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

endpackage

// ===== src/rfd_if.sv =====
interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [15:0] word_value;
   logic [7:0]  left_vertical;
   logic [7:0]  left_horizontal;
   logic [7:0]  right_vertical;
   logic [7:0]  right_horizontal;
   logic [7:0]  button_bits;
   logic [7:0]  extra_byte;

   modport source (output valid, output status, output word_value, output left_vertical,
                   output left_horizontal, output right_vertical, output right_horizontal,
                   output button_bits, output extra_byte, input ready);
   modport sink   (input valid, input status, input word_value, input left_vertical,
                   input left_horizontal, input right_vertical, input right_horizontal,
                   input button_bits, input extra_byte, output ready);
endinterface

// ===== src/rfd_front.sv =====
module rfd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic [7:0]             byte_data,
   input  rfd_pkg::frame_mode_type mode,
   output logic                   push,
   output rfd_pkg::frame_rec_type push_rec
);
   import rfd_pkg::*;

   typedef enum logic [1:0] {
      HUNT,
      GOT_FF,
      PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [3:0]  count_next;
   logic [3:0]  need;
   logic        done;
   byte_type    store_ff [StoreDepth];

   assign count_next = {1'b0, count_ff} + 4'd1;
   assign need       = (mode == MODE_SIX) ? 4'(PayLenSix) : 4'(PayLenNine);
   assign done       = byte_valid && (phase_ff == PAYLOAD) && (count_next >= need);
   assign push       = done;

   always_comb begin
      push_rec.mode = mode;
      for (int i = 0; i < StoreDepth; i++) begin
         push_rec.pay[i] = (3'(i) == count_ff) ? byte_data : store_ff[i];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PAYLOAD: begin
               if (done) begin
                  phase_in = HUNT;
                  count_in = '0;
               end else begin
                  count_in = count_next[2:0];
               end
            end
            GOT_FF: begin
               if (byte_data == HdrSecond) begin
                  phase_in = PAYLOAD;
                  count_in = '0;
               end else if (byte_data == HdrFirst) begin
                  phase_in = GOT_FF;
               end else begin
                  phase_in = HUNT;
               end
            end
            default: begin
               phase_in = (byte_data == HdrFirst) ? GOT_FF : HUNT;
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid && phase_ff == PAYLOAD && {1'b0, count_ff} < 4'(StoreDepth)) begin
         store_ff[count_ff] <= byte_data;
      end
   end

endmodule

// ===== src/rfd_queue.sv =====
module rfd_queue #(
   parameter int QUEUE_DEPTH = rfd_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rfd_pkg::frame_rec_type push_rec,
   input  logic                   pop,
   output rfd_pkg::frame_rec_type pop_rec,
   output rfd_pkg::queue_stat_type stat
);
   import rfd_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   frame_rec_type   mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign stat.full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign pop_rec        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== src/rfd_back.sv =====
module rfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rfd_pkg::queue_stat_type stat,
   input  rfd_pkg::frame_rec_type  rec,
   output logic                    pop,
   rfd_rsp_if.source               rsp_chan
);
   import rfd_pkg::*;

   logic        valid_ff, valid_in;
   logic        status_ff, status_in;
   logic [15:0] word_ff, word_in;
   byte_type    lv_ff, lv_in;
   byte_type    lh_ff, lh_in;
   byte_type    rv_ff, rv_in;
   byte_type    rh_ff, rh_in;
   byte_type    btn_ff, btn_in;
   byte_type    ext_ff, ext_in;
   byte_type    sum;
   logic        six_ok;
   logic        nine_ok;

   assign pop     = stat.not_empty && (!valid_ff || rsp_chan.ready);
   assign sum     = rec.pay[0] + rec.pay[1] + rec.pay[2] + rec.pay[3] + rec.pay[4];
   assign six_ok  = (rec.pay[0] == ~rec.pay[1]) && (rec.pay[2] == ~rec.pay[3]);
   assign nine_ok = (rec.pay[6] == ~sum);

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      word_in   = word_ff;
      lv_in     = lv_ff;
      lh_in     = lh_ff;
      rv_in     = rv_ff;
      rh_in     = rh_ff;
      btn_in    = btn_ff;
      ext_in    = ext_ff;
      if (pop) begin
         valid_in = 1'b1;
         word_in  = '0;
         lv_in    = '0;
         lh_in    = '0;
         rv_in    = '0;
         rh_in    = '0;
         btn_in   = '0;
         ext_in   = '0;
         if (rec.mode == MODE_SIX) begin
            status_in = !six_ok;
            word_in   = {rec.pay[2], rec.pay[0]};
         end else begin
            status_in = !nine_ok;
            lv_in     = rec.pay[0];
            lh_in     = rec.pay[1];
            rv_in     = rec.pay[2];
            rh_in     = rec.pay[3];
            btn_in    = rec.pay[4];
            ext_in    = rec.pay[5];
         end
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      word_ff   <= word_in;
      lv_ff     <= lv_in;
      lh_ff     <= lh_in;
      rv_ff     <= rv_in;
      rh_ff     <= rh_in;
      btn_ff    <= btn_in;
      ext_ff    <= ext_in;
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.word_value       = word_ff;
   assign rsp_chan.left_vertical    = lv_ff;
   assign rsp_chan.left_horizontal  = lh_ff;
   assign rsp_chan.right_vertical   = rv_ff;
   assign rsp_chan.right_horizontal = rh_ff;
   assign rsp_chan.button_bits      = btn_ff;
   assign rsp_chan.extra_byte       = ext_ff;

endmodule

// ===== src/remote_frame_deframer.sv =====
// Channel    Dir   Handshake        Payload
// req_chan   in    valid / ready    rx_byte
// rsp_chan   out   valid / ready    status, word_value, stick, button and extra bytes
// csr (APB)  in    psel / penable   frame_mode at byte address 0
//
// One byte per cycle while the queue has room; the header hunt and payload gather run in a
// state machine; a completed frame is queued, then checked and registered when popped.
// Frames wait in a QUEUE_DEPTH-entry queue; req_chan.ready drops only when it is full.
// rsp_chan stalls never stop byte intake until the queue fills.
// Synchronous reset clears the sync state, queue and output valid; frame_mode resets to 0.
module remote_frame_deframer #(
   parameter int QUEUE_DEPTH = rfd_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   rfd_req_if.sink                       req_chan,
   rfd_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rfd_pkg::CsrAddrW-1:0]  paddr,
   input  logic [rfd_pkg::CsrDataW-1:0]  pwdata,
   output logic [rfd_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready
);
   import rfd_pkg::*;

   frame_mode_type mode_ff, mode_in;
   logic           csr_write;
   logic           byte_take;
   logic           push;
   logic           pop;
   frame_rec_type  push_rec;
   frame_rec_type  pop_rec;
   queue_stat_type stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign mode_in   = (csr_write && !paddr[2]) ? frame_mode_type'(pwdata[0]) : mode_ff;
   assign prdata    = paddr[2] ? '0 : {{(CsrDataW - 1){1'b0}}, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SIX;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign req_chan.ready = !stat.full;
   assign byte_take      = req_chan.valid && req_chan.ready;

   rfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_take),
      .byte_data  (req_chan.rx_byte),
      .mode       (mode_ff),
      .push       (push),
      .push_rec   (push_rec)
   );

   rfd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .stat     (stat)
   );

   rfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .stat     (stat),
      .rec      (pop_rec),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
